@@ sv/delayed_periodic_task_table_defines.svh @@
// assertion macros for the delayed periodic task table
`ifndef DELAYED_PERIODIC_TASK_TABLE_DEFINES_SVH
`define DELAYED_PERIODIC_TASK_TABLE_DEFINES_SVH

// plain invariant, checked at every clock edge out of reset
`define DPTT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define DPTT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DPTT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/dptt_pkg.sv @@
// shared types and codes of the delayed periodic task table
package dptt_pkg;

  localparam int unsigned MaxTasksDef = 8;

  localparam logic [1:0] KIND_CREATE  = 2'd0;
  localparam logic [1:0] KIND_TICK    = 2'd1;
  localparam logic [1:0] KIND_PROCESS = 2'd2;

  localparam logic [1:0] STAT_CREATED  = 2'd0;
  localparam logic [1:0] STAT_FULL     = 2'd1;
  localparam logic [1:0] STAT_DISPATCH = 2'd2;
  localparam logic [1:0] STAT_NONE     = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_PROC
  } state_e;

  typedef struct packed {
    logic        ready;
    logic [15:0] delay;
    logic [15:0] period;
    logic [7:0]  tag;
    logic [15:0] param;
  } entry_t;

endpackage

@@ sv/dptt_ram.sv @@
// generic single write port ram with registered read
module dptt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/delayed_periodic_task_table.sv @@
// top level of the delayed periodic task table
//
// command channel: an item is taken at a rising edge with start high and busy
// low. kind selects create, timer tick or process; tag, parameter, start delay
// and reload period matter only to create, kind 3 is dropped.
// result channel: strobe_o marks each result for exactly one cycle; the
// receiver cannot stall it, so results stream out as they are found.
// per kind, n = entries in use at the time:
//   create  - result on the next cycle, busy stays low
//   tick    - busy while the n entries are read and written back, no result
//   process - busy while the n entries are read, dispatched and compacted; each
//             dispatch is held until the next ready entry is seen and leaves
//             the cycle after that, the final result (last set) in the cycle
//             that busy drops
// the table sits in one ram of MAX_TASKS words; every tick or process pass is
// at most one read and one write a cycle through that single port pair, which
// sets the length of each pass.
// reset clears the entry count and the sequencer; the ram needs no clearing
// as only entries below the count are ever read, each written by its create.
module delayed_periodic_task_table #(
  parameter int unsigned MAX_TASKS = dptt_pkg::MaxTasksDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  task_tag_i,
  input  logic [15:0] task_param_i,
  input  logic [15:0] start_delay_i,
  input  logic [15:0] reload_period_i,
  output logic        strobe_o,
  output logic [1:0]  status_o,
  output logic [2:0]  position_o,
  output logic [7:0]  out_tag_o,
  output logic [15:0] out_param_o,
  output logic        last_o
);

  import dptt_pkg::*;

  `include "delayed_periodic_task_table_defines.svh"

  localparam int unsigned IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CW = $clog2(MAX_TASKS + 1);
  localparam int unsigned EW = $bits(entry_t);

  // sequencer state
  state_e state_q, state_d;

  // table bookkeeping
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] rd_idx_q, rd_idx_d;   // next entry to read
  logic [CW-1:0] keep_q, keep_d;       // write slot of the compacted table
  logic          dv_q, dv_d;           // read data valid this cycle
  logic [IW-1:0] didx_q, didx_d;       // index of the entry in the read data

  // one dispatch held back until we know whether it is the final one
  logic          buf_vld_q, buf_vld_d;
  logic [2:0]    buf_pos_q, buf_pos_d;
  logic [7:0]    buf_tag_q, buf_tag_d;
  logic [15:0]   buf_param_q, buf_param_d;

  // result register
  logic          strobe_q, strobe_d;
  logic [1:0]    status_q, status_d;
  logic [2:0]    pos_q, pos_d;
  logic [7:0]    tag_q, tag_d;
  logic [15:0]   param_q, param_d;
  logic          last_q, last_d;

  // ram access
  logic          ram_we, ram_re;
  logic [IW-1:0] ram_waddr, ram_raddr;
  entry_t        ram_wentry, rd_entry;
  logic [EW-1:0] ram_rdata;

  logic accept;
  logic issue;
  logic walking;

  assign accept  = start && !busy;
  assign walking = (state_q == ST_TICK) || (state_q == ST_PROC);
  assign issue   = walking && (rd_idx_q < count_q);
  assign rd_entry = entry_t'(ram_rdata);

  dptt_ram #(
    .Width (EW),
    .Depth (MAX_TASKS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (EW'(ram_wentry)),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && kind_i == KIND_TICK) begin
          state_d = ST_TICK;
        end else if (accept && kind_i == KIND_PROCESS) begin
          state_d = ST_PROC;
        end
      end
      ST_TICK: begin
        if (!issue) begin
          state_d = ST_IDLE;
        end
      end
      ST_PROC: begin
        if (!issue && !dv_q) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and results
  always_comb begin
    count_d     = count_q;
    rd_idx_d    = rd_idx_q;
    keep_d      = keep_q;
    dv_d        = issue;
    didx_d      = rd_idx_q[IW-1:0];
    buf_vld_d   = buf_vld_q;
    buf_pos_d   = buf_pos_q;
    buf_tag_d   = buf_tag_q;
    buf_param_d = buf_param_q;
    strobe_d    = 1'b0;
    status_d    = STAT_NONE;
    pos_d       = '0;
    tag_d       = '0;
    param_d     = '0;
    last_d      = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = keep_q[IW-1:0];
    ram_wentry  = rd_entry;
    ram_re      = issue;
    ram_raddr   = rd_idx_q[IW-1:0];

    if (issue) begin
      rd_idx_d = rd_idx_q + CW'(1);
    end

    case (state_q)
      ST_IDLE: begin
        rd_idx_d  = '0;
        keep_d    = '0;
        buf_vld_d = 1'b0;
        if (accept && kind_i == KIND_CREATE) begin
          strobe_d = 1'b1;
          last_d   = 1'b1;
          if (count_q >= CW'(MAX_TASKS)) begin
            status_d = STAT_FULL;
          end else begin
            // append a fresh, not ready entry at the end of the table
            status_d          = STAT_CREATED;
            pos_d             = 3'(count_q);
            ram_we            = 1'b1;
            ram_waddr         = count_q[IW-1:0];
            ram_wentry.ready  = 1'b0;
            ram_wentry.delay  = start_delay_i;
            ram_wentry.period = reload_period_i;
            ram_wentry.tag    = task_tag_i;
            ram_wentry.param  = task_param_i;
            count_d           = count_q + CW'(1);
          end
        end
      end
      ST_TICK: begin
        if (dv_q) begin
          // count the delay down, or mark the entry ready once it runs out
          ram_we    = 1'b1;
          ram_waddr = didx_q;
          if (rd_entry.delay == '0) begin
            ram_wentry.ready = 1'b1;
          end else begin
            ram_wentry.delay = rd_entry.delay - 16'd1;
          end
        end
      end
      ST_PROC: begin
        if (dv_q) begin
          if (rd_entry.ready) begin
            // release the held dispatch, this one takes its place
            if (buf_vld_q) begin
              strobe_d = 1'b1;
              status_d = STAT_DISPATCH;
              pos_d    = buf_pos_q;
              tag_d    = buf_tag_q;
              param_d  = buf_param_q;
            end
            buf_vld_d   = 1'b1;
            buf_pos_d   = 3'(didx_q);
            buf_tag_d   = rd_entry.tag;
            buf_param_d = rd_entry.param;
            if (rd_entry.period != '0) begin
              ram_we           = 1'b1;
              ram_wentry.ready = 1'b0;
              ram_wentry.delay = rd_entry.period;
              keep_d           = keep_q + CW'(1);
            end
          end else begin
            // entry survives, slide it down over any removed ones
            ram_we = 1'b1;
            keep_d = keep_q + CW'(1);
          end
        end else if (!issue) begin
          // pass finished: shrink the table and close the transaction
          count_d  = keep_q;
          strobe_d = 1'b1;
          last_d   = 1'b1;
          if (buf_vld_q) begin
            status_d = STAT_DISPATCH;
            pos_d    = buf_pos_q;
            tag_d    = buf_tag_q;
            param_d  = buf_param_q;
          end else begin
            status_d = STAT_NONE;
          end
          buf_vld_d = 1'b0;
        end
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      rd_idx_q  <= '0;
      keep_q    <= '0;
      dv_q      <= 1'b0;
      buf_vld_q <= 1'b0;
      strobe_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      rd_idx_q  <= rd_idx_d;
      keep_q    <= keep_d;
      dv_q      <= dv_d;
      buf_vld_q <= buf_vld_d;
      strobe_q  <= strobe_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    didx_q      <= didx_d;
    buf_pos_q   <= buf_pos_d;
    buf_tag_q   <= buf_tag_d;
    buf_param_q <= buf_param_d;
    status_q    <= status_d;
    pos_q       <= pos_d;
    tag_q       <= tag_d;
    param_q     <= param_d;
    last_q      <= last_d;
  end

  assign busy        = (state_q != ST_IDLE);
  assign strobe_o    = strobe_q;
  assign status_o    = status_q;
  assign position_o  = pos_q;
  assign out_tag_o   = tag_q;
  assign out_param_o = param_q;
  assign last_o      = last_q;

  // checks
  `DPTT_ASSERT(a_count_bound, count_q <= CW'(MAX_TASKS), "entry count above table size")
  `DPTT_ASSERT_IMP(a_keep_bound, state_q == ST_PROC, keep_q <= rd_idx_q, "compaction ahead of reads")
  `DPTT_ASSERT_IMP(a_none_last, strobe_o && status_o == STAT_NONE, last_o, "none ready without last")
  `DPTT_ASSERT_NXT(a_tick_busy, start && !busy && kind_i == KIND_TICK, busy, "tick taken without busy")

endmodule

@@ tb/dptt_checker.sv @@
// checker for the delayed periodic task table: predicts every result and compares
`timescale 1ns / 1ps

module dptt_checker #(
  parameter int unsigned TableDepth = dptt_pkg::MaxTasksDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  task_tag_i,
  input  logic [15:0] task_param_i,
  input  logic [15:0] start_delay_i,
  input  logic [15:0] reload_period_i,
  input  logic        strobe_i,
  input  logic [1:0]  status_i,
  input  logic [2:0]  position_i,
  input  logic [7:0]  out_tag_i,
  input  logic [15:0] out_param_i,
  input  logic        last_i,
  output int          fail_count_o,
  output int          outstanding_o
);

  import dptt_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  position;
    logic [7:0]  tag;
    logic [15:0] param;
    logic        last;
  } result_t;

  entry_t      task_tbl [TableDepth];
  int unsigned entries_used;
  result_t     pending_results[$];
  int          failures = 0;
  int          results_seen = 0;

  assign fail_count_o = failures;

  function automatic result_t make_result(logic [1:0] st, logic [2:0] pos, logic [7:0] tg,
                                          logic [15:0] prm, logic lst);
    result_t r;
    r.status   = st;
    r.position = pos;
    r.tag      = tg;
    r.param    = prm;
    r.last     = lst;
    return r;
  endfunction

  // table update for one accepted transaction, queueing the results it causes
  task automatic apply_command();
    int unsigned kept;
    int unsigned dispatched;
    bit          removed;
    result_t     held;
    begin
      kept = 0;
      dispatched = 0;
      case (kind_i)
        KIND_CREATE: begin
          if (entries_used >= TableDepth) begin
            pending_results.push_back(make_result(STAT_FULL, '0, '0, '0, 1'b1));
          end else begin
            task_tbl[entries_used].ready  = 1'b0;
            task_tbl[entries_used].tag    = task_tag_i;
            task_tbl[entries_used].param  = task_param_i;
            task_tbl[entries_used].delay  = start_delay_i;
            task_tbl[entries_used].period = reload_period_i;
            pending_results.push_back(make_result(STAT_CREATED, entries_used[2:0], '0, '0,
                                                  1'b1));
            entries_used++;
          end
        end
        KIND_TICK: begin
          for (int unsigned i = 0; i < entries_used; i++) begin
            if (task_tbl[i].delay == 16'd0) task_tbl[i].ready = 1'b1;
            else task_tbl[i].delay = task_tbl[i].delay - 16'd1;
          end
        end
        KIND_PROCESS: begin
          // positions reported are those before any one-shot removal
          for (int unsigned i = 0; i < entries_used; i++) begin
            removed = 1'b0;
            if (task_tbl[i].ready) begin
              if (dispatched != 0) pending_results.push_back(held);
              held = make_result(STAT_DISPATCH, i[2:0], task_tbl[i].tag, task_tbl[i].param,
                                 1'b0);
              dispatched++;
              if (task_tbl[i].period != 16'd0) begin
                task_tbl[i].delay = task_tbl[i].period;
                task_tbl[i].ready = 1'b0;
              end else begin
                removed = 1'b1;
              end
            end
            if (!removed) begin
              task_tbl[kept] = task_tbl[i];
              kept++;
            end
          end
          for (int unsigned i = kept; i < entries_used; i++) task_tbl[i].ready = 1'b0;
          entries_used = kept;
          if (dispatched == 0) begin
            pending_results.push_back(make_result(STAT_NONE, '0, '0, '0, 1'b1));
          end else begin
            held.last = 1'b1;
            pending_results.push_back(held);
          end
        end
        default: begin
          // unused kind, dropped by the block
        end
      endcase
    end
  endtask

  task automatic compare_result();
    result_t seen;
    result_t want;
    begin
      seen = make_result(status_i, position_i, out_tag_i, out_param_i, last_i);
      results_seen++;
      if (pending_results.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("[%0t] result %0d with nothing expected: status %0d pos %0d tag %h param %h last %b",
                   $realtime, results_seen, seen.status, seen.position, seen.tag, seen.param,
                   seen.last);
      end else begin
        want = pending_results.pop_front();
        if (seen !== want) begin
          failures++;
          if (failures <= 10)
            $display("[%0t] result %0d mismatch: exp status %0d pos %0d tag %h param %h last %b, got status %0d pos %0d tag %h param %h last %b",
                     $realtime, results_seen, want.status, want.position, want.tag, want.param,
                     want.last, seen.status, seen.position, seen.tag, seen.param, seen.last);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_used = 0;
      for (int unsigned i = 0; i < TableDepth; i++) task_tbl[i] = '0;
      pending_results.delete();
      outstanding_o <= 0;
    end else begin
      if (start_i && !busy_i) apply_command();
      if (strobe_i) compare_result();
      outstanding_o <= pending_results.size();
    end
  end

endmodule

@@ tb/tb_delayed_periodic_task_table.sv @@
// testbench top for the delayed periodic task table: stimulus and verdict
`timescale 1ns / 1ps

module tb_delayed_periodic_task_table;

  import dptt_pkg::*;

  // kind 3 has no meaning to the block, it must be dropped silently
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int RandomItems = 330;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [1:0]  kind;
  logic [7:0]  task_tag;
  logic [15:0] task_param;
  logic [15:0] start_delay;
  logic [15:0] reload_period;
  logic        strobe;
  logic [1:0]  status;
  logic [2:0]  position;
  logic [7:0]  out_tag;
  logic [15:0] out_param;
  logic        last;
  int          fail_count;
  int          outstanding;

  delayed_periodic_task_table DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .kind_i          (kind),
    .task_tag_i      (task_tag),
    .task_param_i    (task_param),
    .start_delay_i   (start_delay),
    .reload_period_i (reload_period),
    .strobe_o        (strobe),
    .status_o        (status),
    .position_o      (position),
    .out_tag_o       (out_tag),
    .out_param_o     (out_param),
    .last_o          (last)
  );

  // watches both channels, keeps its own copy of the table and counts failures
  dptt_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_i          (busy),
    .kind_i          (kind),
    .task_tag_i      (task_tag),
    .task_param_i    (task_param),
    .start_delay_i   (start_delay),
    .reload_period_i (reload_period),
    .strobe_i        (strobe),
    .status_i        (status),
    .position_i      (position),
    .out_tag_i       (out_tag),
    .out_param_i     (out_param),
    .last_i          (last),
    .fail_count_o    (fail_count),
    .outstanding_o   (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // called at a falling edge; holds the transaction until the block takes it,
  // then returns at the next falling edge with start still high
  task automatic issue(input logic [1:0] k, input logic [7:0] tg, input logic [15:0] prm,
                       input logic [15:0] dly, input logic [15:0] per);
    begin
      kind          <= k;
      task_tag      <= tg;
      task_param    <= prm;
      start_delay   <= dly;
      reload_period <= per;
      start         <= 1'b1;
      @(posedge clk_i);
      while (busy) @(posedge clk_i);
      @(negedge clk_i);
    end
  endtask

  // random sender gaps, each further gap taken with a chance of one in five; start is dropped in each gap
  task automatic sender_gaps(input bit quiet);
    begin
      if (!quiet) begin
        while ($urandom_range(0, 99) < 20) begin
          start <= 1'b0;
          @(negedge clk_i);
        end
      end
    end
  endtask

  // hold off until the checker has seen every result it was waiting for
  task automatic drain_results();
    begin
      start <= 1'b0;
      @(negedge clk_i);
      while (outstanding != 0) @(negedge clk_i);
    end
  endtask

  initial begin
    int          done_items;
    int          periodic_left;
    int unsigned pick;
    logic [15:0] dly;
    logic [15:0] per;
    bit          quiet;

    rst_ni        <= 1'b0;
    start         <= 1'b0;
    kind          <= KIND_CREATE;
    task_tag      <= '0;
    task_param    <= '0;
    start_delay   <= '0;
    reload_period <= '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part
    // empty table: process finds nothing, tick does nothing, unused kind dropped
    issue(KIND_PROCESS, 8'h00, 16'h0000, 16'h0000, 16'h0000);
    issue(KIND_TICK,    8'h00, 16'h0000, 16'h0000, 16'h0000);
    issue(KIND_UNUSED,  8'hff, 16'hffff, 16'hffff, 16'hffff);
    // fill all eight slots, mostly one-shots with no delay
    issue(KIND_CREATE,  8'h00, 16'h0000, 16'h0000, 16'h0000);
    issue(KIND_CREATE,  8'hff, 16'hffff, 16'h0000, 16'h0000);
    issue(KIND_CREATE,  8'h11, 16'h1234, 16'h0001, 16'h0000);
    issue(KIND_CREATE,  8'h22, 16'h5678, 16'h0000, 16'h0002);
    issue(KIND_CREATE,  8'h33, 16'h9abc, 16'h0000, 16'h0000);
    issue(KIND_CREATE,  8'h44, 16'hdef0, 16'h0000, 16'h0000);
    issue(KIND_CREATE,  8'h55, 16'h0f0f, 16'h0000, 16'h0000);
    issue(KIND_CREATE,  8'h66, 16'hf0f0, 16'h0000, 16'h0000);
    // table full
    issue(KIND_CREATE,  8'h77, 16'h7777, 16'h0000, 16'h0000);
    // nothing ready before the first tick
    issue(KIND_PROCESS, 8'h00, 16'h0000, 16'h0000, 16'h0000);
    // two ticks make every entry ready, then eight dispatches in one go
    issue(KIND_TICK,    8'h00, 16'h0000, 16'h0000, 16'h0000);
    issue(KIND_TICK,    8'h00, 16'h0000, 16'h0000, 16'h0000);
    issue(KIND_PROCESS, 8'h00, 16'h0000, 16'h0000, 16'h0000);
    // only the periodic entry survives, now at the head; let it reload and fire
    issue(KIND_TICK,    8'h00, 16'h0000, 16'h0000, 16'h0000);
    issue(KIND_TICK,    8'h00, 16'h0000, 16'h0000, 16'h0000);
    issue(KIND_TICK,    8'h00, 16'h0000, 16'h0000, 16'h0000);
    issue(KIND_PROCESS, 8'h00, 16'h0000, 16'h0000, 16'h0000);
    // extreme delay and extreme period
    issue(KIND_CREATE,  8'h5a, 16'ha5a5, 16'hffff, 16'h0000);
    issue(KIND_CREATE,  8'ha5, 16'h5a5a, 16'h0000, 16'hffff);
    issue(KIND_TICK,    8'h00, 16'h0000, 16'h0000, 16'h0000);
    issue(KIND_PROCESS, 8'h00, 16'h0000, 16'h0000, 16'h0000);
    drain_results();

    // random part: short delays so that entries fire and leave; periodic
    // entries never leave, so only a couple are added to keep room free
    done_items    = 0;
    periodic_left = 2;
    while (done_items < RandomItems) begin
      // a stretch in the middle runs back to back
      quiet = (done_items >= 120 && done_items < 220);
      sender_gaps(quiet);
      if (done_items == 300) drain_results();
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        issue(KIND_UNUSED, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
              16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      end else if (pick < 40) begin
        dly = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(0, 15))
                                           : 16'($urandom_range(0, 3));
        per = 16'h0000;
        if (periodic_left > 0 && $urandom_range(0, 7) == 0) begin
          per = 16'($urandom_range(1, 4));
          periodic_left--;
        end
        issue(KIND_CREATE, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)), dly,
              per);
        done_items++;
      end else if (pick < 73) begin
        issue(KIND_TICK, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
              16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        done_items++;
      end else begin
        issue(KIND_PROCESS, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
              16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        done_items++;
      end
    end

    // wind down: all results in, block idle, then wait on in case of
    // a stray strobe
    start <= 1'b0;
    @(negedge clk_i);
    while (outstanding != 0 || busy) @(negedge clk_i);
    repeat (24) @(negedge clk_i);

    if (fail_count == 0) begin
      $display("** delayed_periodic_task_table: PASSED **");
    end else begin
      $display("** delayed_periodic_task_table: FAILED **");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #3_000_000;
    $display("** delayed_periodic_task_table: FAILED **");
    $finish;
  end

endmodule
